>>> rtl/disk_square_warp_bilinear_macros.svh
// assertion macros shared by the disk/square warp modules
`ifndef DISK_SQUARE_WARP_BILINEAR_MACROS_SVH
`define DISK_SQUARE_WARP_BILINEAR_MACROS_SVH

// property checked at every rising clock edge outside reset
`define DSWB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition now implies property at the next edge
`define DSWB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> rtl/dswb_pkg.sv
// types, constants and helper functions of the disk/square warp block
package dswb_pkg;

    localparam int IMAGE_SIZE  = 512;
    localparam int FRAC_BITS   = 8;
    localparam int HALF_SIZE   = IMAGE_SIZE / 2;
    localparam int Q_BITS      = 16;
    localparam int Q_ONE       = 1 << Q_BITS;
    localparam int TWO_ROOT2_Q = 185364;
    localparam int NORM_STEP   = Q_ONE / HALF_SIZE;

    localparam int IDX_W   = 9;
    localparam int PIX_W   = 8;
    localparam int RGB_W   = 3 * PIX_W;
    localparam int NORM_W  = Q_BITS + 2;
    localparam int MAG_W   = Q_BITS + 1;
    localparam int SQ_W    = 2 * MAG_W - 1;
    localparam int K_W     = 18;
    localparam int KP_W    = MAG_W + K_W;
    localparam int ARG_W   = 21;
    localparam int RAD_W   = 19;
    localparam int ROOT_IN_W = 2 * K_W;
    localparam int ROOT_W  = K_W;
    localparam int MX_W    = MAG_W + ROOT_W;
    localparam int T_W     = 21;
    localparam int P_W     = T_W - 1 + IDX_W;
    localparam int FRAC_W  = FRAC_BITS + 1;
    localparam int W_W     = 2 * FRAC_W;
    localparam int BS_W    = W_W + PIX_W + 2;
    localparam int BANK_AW = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NBANK   = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CNT_W      = FIFO_AW + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_WARP_DIRECTION = 1'b0;

    localparam int S_MUL = 0;
    localparam int S_RAD = 1;
    localparam int S_MAP = S_RAD + ROOT_W + 1;
    localparam int S_LOC = S_MAP + 1;
    localparam int S_MEM = S_LOC + 1;
    localparam int NSTG  = S_MEM + 1;

    localparam logic [SQ_W:0] DISK_LIMIT = (SQ_W + 1)'(1) << (2 * Q_BITS);

    typedef enum logic {OP_LOAD = 1'b0, OP_COMPUTE = 1'b1} op_t;
    typedef enum logic {DIR_C2S = 1'b0, DIR_S2C = 1'b1} dir_t;

    typedef struct packed {
        op_t                      op;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic [RGB_W-1:0]         rgb;
        logic [NORM_W-1:0]        u;
        logic [NORM_W-1:0]        v;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    typedef struct packed {
        entry_t e;
        logic   in_disk;
    } meta_t;

    typedef struct packed {
        logic [IDX_W-1:0]  base;
        logic [FRAC_W-1:0] frac;
    } loc_t;

    function automatic logic [NORM_W-1:0] normalize(input logic [IDX_W-1:0] idx);
        logic [NORM_W-1:0] scaled;
        scaled = NORM_W'(idx) * NORM_W'(NORM_STEP);
        return scaled - NORM_W'(Q_ONE);
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic [NORM_W-1:0] x);
        logic [NORM_W-1:0] n;
        n = x[NORM_W-1] ? (~x + NORM_W'(1)) : x;
        return n[MAG_W-1:0];
    endfunction

    // negative or zero root argument gives zero
    function automatic logic [RAD_W-1:0] clamp_rad(input logic [ARG_W-1:0] a);
        logic [RAD_W-1:0] r;
        r = (a[ARG_W-1] || a == '0) ? '0 : a[RAD_W-1:0];
        return r;
    endfunction

    function automatic loc_t locate(input logic [T_W-1:0] t);
        logic [T_W-2:0]   tpos;
        logic [P_W-1:0]   p;
        logic [P_W-1:0]   b;
        logic [P_W-1:0]   rem;
        loc_t             res;
        tpos = t[T_W-1] ? '0 : t[T_W-2:0];
        p = (P_W'(tpos) * P_W'(HALF_SIZE)) >> (Q_BITS + 1 - FRAC_BITS);
        if (p > (P_W'(IMAGE_SIZE - 1) << FRAC_BITS))
            p = P_W'(IMAGE_SIZE - 1) << FRAC_BITS;
        b = p >> FRAC_BITS;
        if (b > P_W'(IMAGE_SIZE - 2))
            b = P_W'(IMAGE_SIZE - 2);
        rem = p - (b << FRAC_BITS);
        res.base = b[IDX_W-1:0];
        res.frac = rem[FRAC_W-1:0];
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] blend_ch(
        input logic [W_W-1:0]   w00, w01, w10, w11,
        input logic [PIX_W-1:0] p00, p01, p10, p11
    );
        logic [BS_W-1:0] s;
        s = BS_W'(w00) * BS_W'(p00) + BS_W'(w01) * BS_W'(p01)
          + BS_W'(w10) * BS_W'(p10) + BS_W'(w11) * BS_W'(p11);
        return s[2*FRAC_BITS +: PIX_W];
    endfunction

endpackage

>>> rtl/dswb_in_if.sv
// input channel: load and compute items
interface dswb_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [dswb_pkg::IDX_W-1:0]  row_index;
    logic [dswb_pkg::IDX_W-1:0]  col_index;
    logic [dswb_pkg::PIX_W-1:0]  red_in;
    logic [dswb_pkg::PIX_W-1:0]  green_in;
    logic [dswb_pkg::PIX_W-1:0]  blue_in;

    modport source (output valid, opcode, row_index, col_index, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, opcode, row_index, col_index, red_in, green_in, blue_in,
                    output ready);
endinterface

>>> rtl/dswb_out_if.sv
// output channel: warped pixels
interface dswb_out_if;
    logic                        valid;
    logic                        ready;
    logic [dswb_pkg::IDX_W-1:0]  out_row;
    logic [dswb_pkg::IDX_W-1:0]  out_col;
    logic [dswb_pkg::PIX_W-1:0]  red_out;
    logic [dswb_pkg::PIX_W-1:0]  green_out;
    logic [dswb_pkg::PIX_W-1:0]  blue_out;
    logic                        inside_disk;

    modport source (output valid, out_row, out_col, red_out, green_out, blue_out, inside_disk,
                    input ready);
    modport sink   (input valid, out_row, out_col, red_out, green_out, blue_out, inside_disk,
                    output ready);
endinterface

>>> rtl/disk_square_warp_bilinear.sv
// top level of the disk/square warp with bilinear resampling
//
// pix_in takes load beats (write one rgb pixel into the 512x512 frame store)
// and compute beats (produce one warped output pixel at the given row and
// column). pix_out returns one beat per compute beat, in order; loads return
// nothing. warp_direction sits at apb byte address 0 (0 circle-to-square,
// 1 square-to-circle); the user must write it only while the block is drained,
// as the block itself does not enforce it. Beats are accepted at one per cycle
// while pix_out does not stall: a four-entry queue feeds a 23-stage mapping
// pipeline whose depth is set by the 18-stage square root units and whose last
// stage reads the 2x2-banked frame store, one neighbor per bank. A stall on
// pix_out freezes the whole back pipeline; the queue keeps taking beats until
// its four entries are full. Reset clears the queue, the pipeline valids and
// warp_direction; the frame store is undefined until written, so only pixels
// that were loaded may be sampled.
module disk_square_warp_bilinear (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dswb_pkg::PADDR_W-1:0]      paddr,
    input  logic [dswb_pkg::PDATA_W-1:0]      pwdata,
    output logic [dswb_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    dswb_in_if.sink                           pix_in,
    dswb_out_if.source                        pix_out
);

    dswb_pkg::dir_t  warp_dir_reg;
    dswb_pkg::head_t head;
    logic            take;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == dswb_pkg::REG_WARP_DIRECTION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            warp_dir_reg <= dswb_pkg::DIR_C2S;
        else if (cfg_wr)
            warp_dir_reg <= dswb_pkg::dir_t'(pwdata[0]);
    end

    assign prdata = (paddr[2] == dswb_pkg::REG_WARP_DIRECTION)
                    ? dswb_pkg::PDATA_W'(warp_dir_reg) : '0;

    dswb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in),
        .head   (head),
        .take   (take)
    );

    dswb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .warp_dir (warp_dir_reg),
        .head     (head),
        .take     (take),
        .pix_out  (pix_out)
    );

endmodule

>>> rtl/dswb_front.sv
// front end: accepts items, normalizes coordinates, queues them for the back end
`include "disk_square_warp_bilinear_macros.svh"

module dswb_front (
    input  logic             clk,
    input  logic             rst_n,
    dswb_in_if.sink          pix_in,
    output dswb_pkg::head_t  head,
    input  logic             take
);

    dswb_pkg::entry_t                 fifo_mem [dswb_pkg::FIFO_DEPTH];
    logic [dswb_pkg::FIFO_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [dswb_pkg::CNT_W-1:0]       count_reg, count_next;
    dswb_pkg::entry_t                 new_entry;
    logic                             push, pop;

    assign pix_in.ready = (count_reg != dswb_pkg::CNT_W'(dswb_pkg::FIFO_DEPTH));
    assign push = pix_in.valid && pix_in.ready;
    assign pop  = take && (count_reg != '0);

    always_comb
    begin
        new_entry.op  = dswb_pkg::op_t'(pix_in.opcode);
        new_entry.row = pix_in.row_index;
        new_entry.col = pix_in.col_index;
        new_entry.rgb = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
        new_entry.u   = dswb_pkg::normalize(pix_in.row_index);
        new_entry.v   = dswb_pkg::normalize(pix_in.col_index);
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + dswb_pkg::CNT_W'(1);
            2'b01:   count_next = count_reg - dswb_pkg::CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + dswb_pkg::FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + dswb_pkg::FIFO_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= new_entry;
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = fifo_mem[rd_ptr_reg];

    `DSWB_ASSERT(a_count_bound, count_reg <= dswb_pkg::CNT_W'(dswb_pkg::FIFO_DEPTH),
                 "queue count beyond depth")
    `DSWB_ASSERT_NEXT(a_push_visible, push && !pop, head.valid, "pushed beat not visible")
    `DSWB_ASSERT_NEXT(a_head_holds, head.valid && !take, $stable(head.entry),
                      "queue head changed while waiting")

endmodule

>>> rtl/dswb_sqrt.sv
// pipelined integer square root, one result bit per stage
module dswb_sqrt (
    input  logic                              clk,
    input  logic                              en,
    input  logic [dswb_pkg::ROOT_IN_W-1:0]    radicand,
    output logic [dswb_pkg::ROOT_W-1:0]       root
);

    localparam int IN_W  = dswb_pkg::ROOT_IN_W;
    localparam int OUT_W = dswb_pkg::ROOT_W;
    localparam int REM_W = OUT_W + 3;

    logic [IN_W-1:0]  x_reg   [OUT_W];
    logic [REM_W-1:0] rem_reg [OUT_W];
    logic [OUT_W-1:0] q_reg   [OUT_W];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_stage
        logic [IN_W-1:0]  x_prev;
        logic [REM_W-1:0] rem_prev, rem_sh, trial;
        logic [OUT_W-1:0] q_prev;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign x_prev   = radicand;
            assign rem_prev = '0;
            assign q_prev   = '0;
        end
        else
        begin : g_rest
            assign x_prev   = x_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign q_prev   = q_reg[k-1];
        end

        assign rem_sh = {rem_prev[REM_W-3:0], x_prev[IN_W-1 -: 2]};
        assign trial  = REM_W'({q_prev, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]   <= x_prev << 2;
                rem_reg[k] <= ge ? (rem_sh - trial) : rem_sh;
                q_reg[k]   <= {q_prev[OUT_W-2:0], ge};
            end
        end
    end

    assign root = q_reg[OUT_W-1];

endmodule

>>> rtl/dswb_back.sv
// back end: mapping pipeline, banked frame store and bilinear blend
`include "disk_square_warp_bilinear_macros.svh"

module dswb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  dswb_pkg::dir_t   warp_dir,
    input  dswb_pkg::head_t  head,
    output logic             take,
    dswb_out_if.source       pix_out
);

    localparam int NSTG = dswb_pkg::NSTG;

    logic                              en;
    logic [NSTG-1:0]                   valid_reg, valid_next;
    dswb_pkg::meta_t                   meta_reg  [NSTG];
    dswb_pkg::meta_t                   meta_next [NSTG];

    // stage products and datapath registers
    logic [dswb_pkg::SQ_W-1:0]         sq_u_reg, sq_v_reg;
    logic [dswb_pkg::K_W-1:0]          ku_mag_reg, kv_mag_reg;
    logic [dswb_pkg::RAD_W-1:0]        rad_reg [4];
    logic [dswb_pkg::ROOT_W-1:0]       root    [4];
    logic [dswb_pkg::MX_W-1:0]         mx_reg, my_reg;
    logic [dswb_pkg::T_W-1:0]          dx_reg, dy_reg;
    dswb_pkg::loc_t                    loc_r_reg, loc_c_reg;
    logic [dswb_pkg::W_W-1:0]          w_reg [4];
    logic                              par_r_reg, par_c_reg;
    logic [dswb_pkg::RGB_W-1:0]        rd_reg [dswb_pkg::NBANK];

    logic                              out_valid_reg;
    logic [dswb_pkg::IDX_W-1:0]        out_row_reg, out_col_reg;
    logic [dswb_pkg::RGB_W-1:0]        out_rgb_reg;
    logic                              out_inside_reg;

    logic                              inside_calc;
    logic [dswb_pkg::MAG_W-1:0]        mag_u0, mag_v0, uu, vv, mag_u20, mag_v20;
    logic [dswb_pkg::ARG_W-1:0]        ku_s, kv_s, base_x, base_y;
    logic [dswb_pkg::RAD_W-1:0]        rad_next [4];
    logic [dswb_pkg::T_W-1:0]          qx, qy, tx, ty;
    dswb_pkg::loc_t                    loc_r, loc_c;
    logic [dswb_pkg::FRAC_W-1:0]       one_fr, one_fc;
    logic [dswb_pkg::RGB_W-1:0]        p00, p01, p10, p11;
    logic [dswb_pkg::RGB_W-1:0]        blend_rgb;
    logic                              wr_en;
    logic [1:0]                        wr_bank;
    logic [dswb_pkg::BANK_AW-1:0]      wr_addr;
    logic [dswb_pkg::IDX_W-1:0]        row_b1, col_b1;

    assign en   = !out_valid_reg || pix_out.ready;
    assign take = en && head.valid;

    // stage 0 products
    assign mag_u0 = dswb_pkg::mag(head.entry.u);
    assign mag_v0 = dswb_pkg::mag(head.entry.v);

    // stage 1 root arguments
    assign uu = dswb_pkg::MAG_W'(sq_u_reg >> dswb_pkg::Q_BITS);
    assign vv = dswb_pkg::MAG_W'(sq_v_reg >> dswb_pkg::Q_BITS);

    always_comb
    begin
        ku_s = dswb_pkg::ARG_W'(ku_mag_reg);
        kv_s = dswb_pkg::ARG_W'(kv_mag_reg);
        if (meta_reg[dswb_pkg::S_MUL].e.u[dswb_pkg::NORM_W-1])
            ku_s = ~ku_s + dswb_pkg::ARG_W'(1);
        if (meta_reg[dswb_pkg::S_MUL].e.v[dswb_pkg::NORM_W-1])
            kv_s = ~kv_s + dswb_pkg::ARG_W'(1);
        base_x = dswb_pkg::ARG_W'(2 * dswb_pkg::Q_ONE) + dswb_pkg::ARG_W'(uu)
               - dswb_pkg::ARG_W'(vv);
        base_y = dswb_pkg::ARG_W'(2 * dswb_pkg::Q_ONE) - dswb_pkg::ARG_W'(uu)
               + dswb_pkg::ARG_W'(vv);
        if (warp_dir == dswb_pkg::DIR_S2C)
        begin
            rad_next[0] = dswb_pkg::clamp_rad(base_x + ku_s);
            rad_next[1] = dswb_pkg::clamp_rad(base_x - ku_s);
            rad_next[2] = dswb_pkg::clamp_rad(base_y + kv_s);
            rad_next[3] = dswb_pkg::clamp_rad(base_y - kv_s);
            inside_calc = ((dswb_pkg::SQ_W + 1)'(sq_u_reg) + (dswb_pkg::SQ_W + 1)'(sq_v_reg))
                          <= dswb_pkg::DISK_LIMIT;
        end
        else
        begin
            rad_next[0] = dswb_pkg::RAD_W'(dswb_pkg::Q_ONE) - dswb_pkg::RAD_W'(vv >> 1);
            rad_next[1] = dswb_pkg::RAD_W'(dswb_pkg::Q_ONE) - dswb_pkg::RAD_W'(uu >> 1);
            rad_next[2] = '0;
            rad_next[3] = '0;
            inside_calc = 1'b1;
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_root
        dswb_sqrt u_sqrt (
            .clk      (clk),
            .en       (en),
            .radicand (dswb_pkg::ROOT_IN_W'(rad_reg[i]) << dswb_pkg::Q_BITS),
            .root     (root[i])
        );
    end

    // stage after the roots
    assign mag_u20 = dswb_pkg::mag(meta_reg[dswb_pkg::S_MAP-1].e.u);
    assign mag_v20 = dswb_pkg::mag(meta_reg[dswb_pkg::S_MAP-1].e.v);

    // source position and neighbor location
    always_comb
    begin
        qx = dswb_pkg::T_W'(mx_reg >> dswb_pkg::Q_BITS) << 1;
        qy = dswb_pkg::T_W'(my_reg >> dswb_pkg::Q_BITS) << 1;
        if (meta_reg[dswb_pkg::S_MAP].e.u[dswb_pkg::NORM_W-1])
            qx = ~qx + dswb_pkg::T_W'(1);
        if (meta_reg[dswb_pkg::S_MAP].e.v[dswb_pkg::NORM_W-1])
            qy = ~qy + dswb_pkg::T_W'(1);
        if (warp_dir == dswb_pkg::DIR_S2C)
        begin
            tx = dx_reg + dswb_pkg::T_W'(2 * dswb_pkg::Q_ONE);
            ty = dy_reg + dswb_pkg::T_W'(2 * dswb_pkg::Q_ONE);
        end
        else
        begin
            tx = qx + dswb_pkg::T_W'(2 * dswb_pkg::Q_ONE);
            ty = qy + dswb_pkg::T_W'(2 * dswb_pkg::Q_ONE);
        end
        loc_r = dswb_pkg::locate(tx);
        loc_c = dswb_pkg::locate(ty);
    end

    // memory stage: loads write here, in order with the reads
    assign one_fr  = dswb_pkg::FRAC_W'(1 << dswb_pkg::FRAC_BITS) - loc_r_reg.frac;
    assign one_fc  = dswb_pkg::FRAC_W'(1 << dswb_pkg::FRAC_BITS) - loc_c_reg.frac;
    assign row_b1  = loc_r_reg.base + dswb_pkg::IDX_W'(1);
    assign col_b1  = loc_c_reg.base + dswb_pkg::IDX_W'(1);
    assign wr_en   = en && valid_reg[dswb_pkg::S_LOC]
                     && (meta_reg[dswb_pkg::S_LOC].e.op == dswb_pkg::OP_LOAD);
    assign wr_bank = {meta_reg[dswb_pkg::S_LOC].e.row[0], meta_reg[dswb_pkg::S_LOC].e.col[0]};
    assign wr_addr = {meta_reg[dswb_pkg::S_LOC].e.row[dswb_pkg::IDX_W-1:1],
                      meta_reg[dswb_pkg::S_LOC].e.col[dswb_pkg::IDX_W-1:1]};

    for (genvar b = 0; b < dswb_pkg::NBANK; b++)
    begin : g_bank
        localparam logic PR = 1'(b >> 1);
        localparam logic PC = 1'(b & 1);
        logic [dswb_pkg::RGB_W-1:0]   mem [dswb_pkg::BANK_DEPTH];
        logic [dswb_pkg::IDX_W-1:0]   r_sel, c_sel;
        logic [dswb_pkg::BANK_AW-1:0] raddr;

        assign r_sel = (loc_r_reg.base[0] == PR) ? loc_r_reg.base : row_b1;
        assign c_sel = (loc_c_reg.base[0] == PC) ? loc_c_reg.base : col_b1;
        assign raddr = {r_sel[dswb_pkg::IDX_W-1:1], c_sel[dswb_pkg::IDX_W-1:1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wr_en && (wr_bank == 2'(b)))
                    mem[wr_addr] <= meta_reg[dswb_pkg::S_LOC].e.rgb;
                rd_reg[b] <= mem[raddr];
            end
        end
    end

    // route banks to the four neighbor positions
    always_comb
    begin
        case ({par_r_reg, par_c_reg})
            2'b01:
            begin
                p00 = rd_reg[1]; p01 = rd_reg[0]; p10 = rd_reg[3]; p11 = rd_reg[2];
            end
            2'b10:
            begin
                p00 = rd_reg[2]; p01 = rd_reg[3]; p10 = rd_reg[0]; p11 = rd_reg[1];
            end
            2'b11:
            begin
                p00 = rd_reg[3]; p01 = rd_reg[2]; p10 = rd_reg[1]; p11 = rd_reg[0];
            end
            default:
            begin
                p00 = rd_reg[0]; p01 = rd_reg[1]; p10 = rd_reg[2]; p11 = rd_reg[3];
            end
        endcase
        for (int c = 0; c < 3; c++)
            blend_rgb[c*dswb_pkg::PIX_W +: dswb_pkg::PIX_W] = dswb_pkg::blend_ch(
                w_reg[0], w_reg[1], w_reg[2], w_reg[3],
                p00[c*dswb_pkg::PIX_W +: dswb_pkg::PIX_W],
                p01[c*dswb_pkg::PIX_W +: dswb_pkg::PIX_W],
                p10[c*dswb_pkg::PIX_W +: dswb_pkg::PIX_W],
                p11[c*dswb_pkg::PIX_W +: dswb_pkg::PIX_W]);
    end

    // item line that runs beside the datapath
    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (k == 0)
            begin
                meta_next[k].e       = head.entry;
                meta_next[k].in_disk = 1'b1;
                valid_next[k]        = head.valid;
            end
            else
            begin
                meta_next[k]  = meta_reg[k-1];
                valid_next[k] = valid_reg[k-1];
            end
        end
        meta_next[dswb_pkg::S_RAD].in_disk = inside_calc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[dswb_pkg::S_MEM]
                             && (meta_reg[dswb_pkg::S_MEM].e.op == dswb_pkg::OP_COMPUTE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSTG; k++)
                meta_reg[k] <= meta_next[k];
            sq_u_reg   <= dswb_pkg::SQ_W'(mag_u0) * dswb_pkg::SQ_W'(mag_u0);
            sq_v_reg   <= dswb_pkg::SQ_W'(mag_v0) * dswb_pkg::SQ_W'(mag_v0);
            ku_mag_reg <= dswb_pkg::K_W'((dswb_pkg::KP_W'(mag_u0)
                          * dswb_pkg::KP_W'(dswb_pkg::TWO_ROOT2_Q)) >> dswb_pkg::Q_BITS);
            kv_mag_reg <= dswb_pkg::K_W'((dswb_pkg::KP_W'(mag_v0)
                          * dswb_pkg::KP_W'(dswb_pkg::TWO_ROOT2_Q)) >> dswb_pkg::Q_BITS);
            for (int i = 0; i < 4; i++)
                rad_reg[i] <= rad_next[i];
            mx_reg <= dswb_pkg::MX_W'(mag_u20) * dswb_pkg::MX_W'(root[0]);
            my_reg <= dswb_pkg::MX_W'(mag_v20) * dswb_pkg::MX_W'(root[1]);
            dx_reg <= dswb_pkg::T_W'(root[0]) - dswb_pkg::T_W'(root[1]);
            dy_reg <= dswb_pkg::T_W'(root[2]) - dswb_pkg::T_W'(root[3]);
            loc_r_reg <= loc_r;
            loc_c_reg <= loc_c;
            w_reg[0]  <= dswb_pkg::W_W'(one_fr) * dswb_pkg::W_W'(one_fc);
            w_reg[1]  <= dswb_pkg::W_W'(one_fr) * dswb_pkg::W_W'(loc_c_reg.frac);
            w_reg[2]  <= dswb_pkg::W_W'(loc_r_reg.frac) * dswb_pkg::W_W'(one_fc);
            w_reg[3]  <= dswb_pkg::W_W'(loc_r_reg.frac) * dswb_pkg::W_W'(loc_c_reg.frac);
            par_r_reg <= loc_r_reg.base[0];
            par_c_reg <= loc_c_reg.base[0];
            out_row_reg    <= meta_reg[dswb_pkg::S_MEM].e.row;
            out_col_reg    <= meta_reg[dswb_pkg::S_MEM].e.col;
            out_inside_reg <= meta_reg[dswb_pkg::S_MEM].in_disk;
            out_rgb_reg    <= meta_reg[dswb_pkg::S_MEM].in_disk ? blend_rgb : '0;
        end
    end

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.out_row     = out_row_reg;
    assign pix_out.out_col     = out_col_reg;
    assign pix_out.red_out     = out_rgb_reg[2*dswb_pkg::PIX_W +: dswb_pkg::PIX_W];
    assign pix_out.green_out   = out_rgb_reg[dswb_pkg::PIX_W +: dswb_pkg::PIX_W];
    assign pix_out.blue_out    = out_rgb_reg[0 +: dswb_pkg::PIX_W];
    assign pix_out.inside_disk = out_inside_reg;

    `DSWB_ASSERT_NEXT(a_stall_freezes, out_valid_reg && !pix_out.ready, $stable(valid_reg),
                      "pipeline moved while output stalled")
    `DSWB_ASSERT(a_outside_black,
                 (pix_out.valid && !pix_out.inside_disk) |->
                 (pix_out.red_out == '0 && pix_out.green_out == '0 && pix_out.blue_out == '0),
                 "outside pixel not black")
    `DSWB_ASSERT(a_result_source, $rose(out_valid_reg) |-> $past(valid_reg[dswb_pkg::S_MEM]),
                 "result without an item in the last stage")

endmodule

>>> tb/tb_disk_square_warp_bilinear.sv
// self-checking testbench for the disk/square warp: loads, warped computes, both directions
module tb_disk_square_warp_bilinear;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEM_TARGET    = 1050;

    typedef struct packed {
        logic [dswb_pkg::IDX_W-1:0] row;
        logic [dswb_pkg::IDX_W-1:0] col;
        logic [dswb_pkg::PIX_W-1:0] red;
        logic [dswb_pkg::PIX_W-1:0] green;
        logic [dswb_pkg::PIX_W-1:0] blue;
        logic                       in_disk;
    } pixel_t;

    typedef struct {
        dswb_pkg::dir_t             dir;
        dswb_pkg::op_t              op;
        logic [dswb_pkg::IDX_W-1:0] row;
        logic [dswb_pkg::IDX_W-1:0] col;
        logic [dswb_pkg::PIX_W-1:0] red;
        logic [dswb_pkg::PIX_W-1:0] green;
        logic [dswb_pkg::PIX_W-1:0] blue;
        bit                         typed;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [dswb_pkg::PADDR_W-1:0] paddr;
    logic [dswb_pkg::PDATA_W-1:0] pwdata;
    logic [dswb_pkg::PDATA_W-1:0] prdata;
    logic pready;

    dswb_in_if  pix_in_bus();
    dswb_out_if pix_out_bus();

    disk_square_warp_bilinear dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pix_in(pix_in_bus), .pix_out(pix_out_bus)
    );

    // mirror of the block's state
    logic [dswb_pkg::RGB_W-1:0] pixel_mem [dswb_pkg::IMAGE_SIZE*dswb_pkg::IMAGE_SIZE];
    bit                         pixel_loaded [dswb_pkg::IMAGE_SIZE*dswb_pkg::IMAGE_SIZE];
    dswb_pkg::dir_t             cur_dir;

    pixel_t pending_pixels[$];
    int     mismatches;
    int     items_sent;
    int     quiet_cycles;
    bit     calm;

    step_t directed_steps[] = '{
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_LOAD,    9'd0,   9'd0,   8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_LOAD,    9'd511, 9'd511, 8'hff, 8'hff, 8'hff, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_LOAD,    9'd0,   9'd511, 8'hff, 8'h00, 8'haa, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_LOAD,    9'd511, 9'd0,   8'h55, 8'hff, 8'h00, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_COMPUTE, 9'd0,   9'd0,   8'hff, 8'hff, 8'hff, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_COMPUTE, 9'd511, 9'd511, 8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_COMPUTE, 9'd0,   9'd511, 8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_COMPUTE, 9'd511, 9'd0,   8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_COMPUTE, 9'd256, 9'd256, 8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_COMPUTE, 9'd255, 9'd255, 8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_C2S, dswb_pkg::OP_COMPUTE, 9'd1,   9'd510, 8'h00, 8'h00, 8'h00, 1'b0},
        // corners lie outside the disk: black, not sampled
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd0,   9'd0,   8'h00, 8'h00, 8'h00, 1'b1},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd511, 9'd511, 8'h00, 8'h00, 8'h00, 1'b1},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd0,   9'd511, 8'h00, 8'h00, 8'h00, 1'b1},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd511, 9'd0,   8'h00, 8'h00, 8'h00, 1'b1},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd256, 9'd256, 8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd256, 9'd0,   8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd0,   9'd256, 8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd128, 9'd128, 8'h00, 8'h00, 8'h00, 1'b0},
        '{dswb_pkg::DIR_S2C, dswb_pkg::OP_COMPUTE, 9'd300, 9'd77,  8'h00, 8'h00, 8'h00, 1'b0}
    };

    function automatic longint qmul(longint a, longint b);
        bit     neg;
        longint p;
        neg = (a < 0) != (b < 0);
        p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> 16;
        return neg ? -p : p;
    endfunction

    function automatic longint qroot(longint a);
        longint unsigned x, r, b;
        if (a <= 0)
            return 0;
        x = longint'(a) << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint to_normal(logic [dswb_pkg::IDX_W-1:0] idx);
        return (longint'(idx) * dswb_pkg::Q_ONE) / dswb_pkg::HALF_SIZE - dswb_pkg::Q_ONE;
    endfunction

    function automatic void source_pos(longint t, output int base, output int frac);
        longint p;
        if (t < 0)
            t = 0;
        p = (t * dswb_pkg::HALF_SIZE) >>> (dswb_pkg::Q_BITS + 1 - dswb_pkg::FRAC_BITS);
        if (p > (longint'(dswb_pkg::IMAGE_SIZE - 1) << dswb_pkg::FRAC_BITS))
            p = longint'(dswb_pkg::IMAGE_SIZE - 1) << dswb_pkg::FRAC_BITS;
        base = int'(p >>> dswb_pkg::FRAC_BITS);
        if (base > dswb_pkg::IMAGE_SIZE - 2)
            base = dswb_pkg::IMAGE_SIZE - 2;
        frac = int'(p - (longint'(base) << dswb_pkg::FRAC_BITS));
    endfunction

    // warp geometry: where a compute samples, and whether it samples at all
    function automatic bit warp_sample_point(dswb_pkg::dir_t dir,
                                             logic [dswb_pkg::IDX_W-1:0] row,
                                             logic [dswb_pkg::IDX_W-1:0] col, output int br,
                                             output int fr, output int bc, output int fc);
        longint u, v, tx, ty, uu, vv, ku, kv;
        bit     in_disk;
        u = to_normal(row);
        v = to_normal(col);
        in_disk = 1'b1;
        tx = 0;
        ty = 0;
        if (dir == dswb_pkg::DIR_C2S)
        begin
            tx = 2 * qmul(u, qroot(dswb_pkg::Q_ONE - qmul(v, v) / 2)) + 2 * dswb_pkg::Q_ONE;
            ty = 2 * qmul(v, qroot(dswb_pkg::Q_ONE - qmul(u, u) / 2)) + 2 * dswb_pkg::Q_ONE;
        end
        else
        begin
            in_disk = (u * u + v * v) <= longint'(dswb_pkg::Q_ONE) * dswb_pkg::Q_ONE;
            if (in_disk)
            begin
                uu = qmul(u, u);
                vv = qmul(v, v);
                ku = qmul(dswb_pkg::TWO_ROOT2_Q, u);
                kv = qmul(dswb_pkg::TWO_ROOT2_Q, v);
                tx = qroot(2 * dswb_pkg::Q_ONE + uu - vv + ku)
                   - qroot(2 * dswb_pkg::Q_ONE + uu - vv - ku) + 2 * dswb_pkg::Q_ONE;
                ty = qroot(2 * dswb_pkg::Q_ONE - uu + vv + kv)
                   - qroot(2 * dswb_pkg::Q_ONE - uu + vv - kv) + 2 * dswb_pkg::Q_ONE;
            end
        end
        source_pos(tx, br, fr);
        source_pos(ty, bc, fc);
        return in_disk;
    endfunction

    function automatic logic [dswb_pkg::PIX_W-1:0] mix_channel(int br, int bc, int fr, int fc,
                                                               int sh);
        longint one, s, p00, p01, p10, p11;
        one = longint'(1) << dswb_pkg::FRAC_BITS;
        p00 = (pixel_mem[br * dswb_pkg::IMAGE_SIZE + bc] >> sh) & 8'hff;
        p01 = (pixel_mem[br * dswb_pkg::IMAGE_SIZE + bc + 1] >> sh) & 8'hff;
        p10 = (pixel_mem[(br + 1) * dswb_pkg::IMAGE_SIZE + bc] >> sh) & 8'hff;
        p11 = (pixel_mem[(br + 1) * dswb_pkg::IMAGE_SIZE + bc + 1] >> sh) & 8'hff;
        s = (one - fr) * (one - fc) * p00 + (one - fr) * fc * p01
          + fr * (one - fc) * p10 + fr * fc * p11;
        return dswb_pkg::PIX_W'(s >>> (2 * dswb_pkg::FRAC_BITS));
    endfunction

    function automatic pixel_t warp_predict(logic [dswb_pkg::IDX_W-1:0] row,
                                            logic [dswb_pkg::IDX_W-1:0] col);
        pixel_t px;
        int     br, fr, bc, fc;
        px = '0;
        px.row = row;
        px.col = col;
        px.in_disk = warp_sample_point(cur_dir, row, col, br, fr, bc, fc);
        if (px.in_disk)
        begin
            px.red   = mix_channel(br, bc, fr, fc, 16);
            px.green = mix_channel(br, bc, fr, fc, 8);
            px.blue  = mix_channel(br, bc, fr, fc, 0);
        end
        return px;
    endfunction

    task automatic note_mismatch(string what);
        if (mismatches < 10)
            $display("[%0t] %s", $realtime, what);
        mismatches++;
    endtask

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // one beat on pix_in; valid stays high across back-to-back beats
    task automatic send_beat(dswb_pkg::op_t op, logic [dswb_pkg::IDX_W-1:0] row,
                             logic [dswb_pkg::IDX_W-1:0] col,
                             logic [dswb_pkg::PIX_W-1:0] r, logic [dswb_pkg::PIX_W-1:0] g,
                             logic [dswb_pkg::PIX_W-1:0] b,
                             bit typed = 1'b0, pixel_t typed_px = '0);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 23)
        begin
            pix_in_bus.valid = 1'b0;
            @(negedge clk);
        end
        pix_in_bus.valid     = 1'b1;
        pix_in_bus.opcode    = op;
        pix_in_bus.row_index = row;
        pix_in_bus.col_index = col;
        pix_in_bus.red_in    = r;
        pix_in_bus.green_in  = g;
        pix_in_bus.blue_in   = b;
        do
            @(posedge clk);
        while (!pix_in_bus.ready);
        items_sent++;
        if (op == dswb_pkg::OP_LOAD)
        begin
            pixel_mem[row * dswb_pkg::IMAGE_SIZE + col]    = {r, g, b};
            pixel_loaded[row * dswb_pkg::IMAGE_SIZE + col] = 1'b1;
        end
        else
        begin
            pending_pixels.push_back(typed ? typed_px : warp_predict(row, col));
        end
    endtask

    task automatic idle_input();
        @(negedge clk);
        pix_in_bus.valid = 1'b0;
    endtask

    // load any of the four sampled neighbors not yet written
    task automatic prime_neighbors(logic [dswb_pkg::IDX_W-1:0] row,
                                   logic [dswb_pkg::IDX_W-1:0] col);
        int br, fr, bc, fc;
        int nr, nc;
        if (!warp_sample_point(cur_dir, row, col, br, fr, bc, fc))
            return;
        for (int k = 0; k < 4; k++)
        begin
            nr = br + k / 2;
            nc = bc + k % 2;
            if (!pixel_loaded[nr * dswb_pkg::IMAGE_SIZE + nc])
                send_beat(dswb_pkg::OP_LOAD, dswb_pkg::IDX_W'(nr), dswb_pkg::IDX_W'(nc),
                          dswb_pkg::PIX_W'($urandom), dswb_pkg::PIX_W'($urandom),
                          dswb_pkg::PIX_W'($urandom));
        end
    endtask

    task automatic compute_pixel(logic [dswb_pkg::IDX_W-1:0] row,
                                 logic [dswb_pkg::IDX_W-1:0] col);
        prime_neighbors(row, col);
        send_beat(dswb_pkg::OP_COMPUTE, row, col, dswb_pkg::PIX_W'($urandom),
                  dswb_pkg::PIX_W'($urandom), dswb_pkg::PIX_W'($urandom));
    endtask

    task automatic drain_outputs();
        idle_input();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(dswb_pkg::dir_t dir);
        drain_outputs();
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = dswb_pkg::PADDR_W'(4 * int'(dswb_pkg::REG_WARP_DIRECTION));
        pwdata  = dswb_pkg::PDATA_W'(dir);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[0] !== dir)
            note_mismatch($sformatf("warp_direction readback exp %0d got %0h", dir, prdata));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        cur_dir = dir;
    endtask

    // result side: random stalls, compare against the oldest expectation
    always @(negedge clk)
        pix_out_bus.ready <= rst_n && (calm || $urandom_range(99) >= 23);

    always @(posedge clk)
    begin
        pixel_t want, got;
        if (pix_out_bus.valid && pix_out_bus.ready)
        begin
            got = '{pix_out_bus.out_row, pix_out_bus.out_col, pix_out_bus.red_out,
                    pix_out_bus.green_out, pix_out_bus.blue_out, pix_out_bus.inside_disk};
            if (pending_pixels.size() == 0)
            begin
                note_mismatch($sformatf("unexpected beat %p", got));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.row !== want.row || got.col !== want.col)
                    note_mismatch($sformatf("position exp %0d,%0d got %0d,%0d",
                                            want.row, want.col, got.row, got.col));
                if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
                    note_mismatch($sformatf("pixel %0d,%0d rgb exp %h%h%h got %h%h%h",
                                            want.row, want.col, want.red, want.green,
                                            want.blue, got.red, got.green, got.blue));
                if (got.in_disk !== want.in_disk)
                    note_mismatch($sformatf("pixel %0d,%0d inside_disk exp %0d got %0d",
                                            want.row, want.col, want.in_disk, got.in_disk));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        pixel_t typed_px;
        int     phase;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_in_bus.valid = 1'b0;
        pix_in_bus.opcode = dswb_pkg::OP_LOAD;
        pix_in_bus.row_index = '0;
        pix_in_bus.col_index = '0;
        pix_in_bus.red_in = '0;
        pix_in_bus.green_in = '0;
        pix_in_bus.blue_in = '0;
        pix_out_bus.ready = 1'b0;
        mismatches = 0;
        items_sent = 0;
        quiet_cycles = 0;
        calm = 1'b0;
        cur_dir = dswb_pkg::DIR_C2S;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_direction(dswb_pkg::DIR_C2S);
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].dir != cur_dir)
                set_direction(directed_steps[i].dir);
            if (directed_steps[i].op == dswb_pkg::OP_LOAD)
            begin
                send_beat(dswb_pkg::OP_LOAD, directed_steps[i].row, directed_steps[i].col,
                          directed_steps[i].red, directed_steps[i].green,
                          directed_steps[i].blue);
            end
            else if (directed_steps[i].typed)
            begin
                typed_px = '{directed_steps[i].row, directed_steps[i].col, 8'h00, 8'h00,
                             8'h00, 1'b0};
                send_beat(dswb_pkg::OP_COMPUTE, directed_steps[i].row, directed_steps[i].col,
                          directed_steps[i].red, directed_steps[i].green,
                          directed_steps[i].blue, 1'b1, typed_px);
            end
            else
            begin
                compute_pixel(directed_steps[i].row, directed_steps[i].col);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // switch direction every ~200 beats, alternating extremes
            if (items_sent / 200 != phase)
            begin
                phase = items_sent / 200;
                set_direction(phase % 2 ? dswb_pkg::DIR_C2S : dswb_pkg::DIR_S2C);
            end
            calm = (items_sent >= 450 && items_sent < 600);
            if (items_sent >= 700 && items_sent < 702)
                drain_outputs();
            case ($urandom_range(9))
                0, 1:
                    send_beat(dswb_pkg::OP_LOAD, dswb_pkg::IDX_W'($urandom),
                              dswb_pkg::IDX_W'($urandom), dswb_pkg::PIX_W'($urandom),
                              dswb_pkg::PIX_W'($urandom), dswb_pkg::PIX_W'($urandom));
                default:
                    compute_pixel(dswb_pkg::IDX_W'($urandom), dswb_pkg::IDX_W'($urandom));
            endcase
        end
        calm = 1'b0;

        drain_outputs();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
